@@ rtl/core/mts_pkg.sv @@
// Shared constants, codes and state type for the melody tone sequencer.
package mts_pkg;

	localparam int DEF_MAX_NOTES        = 256;
	localparam int DEF_TICKS_PER_SECOND = 1000;

	localparam int ACTION_W   = 2;
	localparam int ADDR_W     = 8;
	localparam int FREQ_W     = 16;
	localparam int DUR_W      = 16;
	localparam int LEN_W      = 9;
	localparam int CMP_W      = 8;
	localparam int POS_W      = 9;
	localparam int VOL_W      = 7;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [ACTION_W-1:0] ACT_TICK  = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_START = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_VOLUME  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SILENCE = 2'd1;

	localparam logic [15:0] BASE_RATE     = 16'd62500;
	localparam logic [15:0] PERCENT       = 16'd100;
	localparam logic [15:0] SILENCE_RESET = 16'd50;

	localparam logic [3:0] DIV_LAST = 4'd15;
	localparam logic [3:0] MUL_LAST = 4'd6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FETCH,
		ST_PDIV,
		ST_MUL,
		ST_DDIV,
		ST_DONE
	} mts_state_t;

endpackage

@@ rtl/core/mts_in_if.sv @@
// Request channel interface carrying one sequencer command.
interface mts_in_if import mts_pkg::*;;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [ADDR_W-1:0]   note_address;
	logic [FREQ_W-1:0]   note_frequency;
	logic [DUR_W-1:0]    note_duration;
	logic [LEN_W-1:0]    song_length;

	modport source (output valid, action, note_address, note_frequency, note_duration,
		song_length, input ready);
	modport sink (input valid, action, note_address, note_frequency, note_duration,
		song_length, output ready);
endinterface

@@ rtl/core/mts_out_if.sv @@
// Result channel interface carrying the tone generator status.
interface mts_out_if import mts_pkg::*;;
	logic             valid;
	logic             ready;
	logic             tone_on;
	logic [CMP_W-1:0] period_compare;
	logic [CMP_W-1:0] duty_compare;
	logic             second_pulse;
	logic [POS_W-1:0] note_position;

	modport source (output valid, tone_on, period_compare, duty_compare, second_pulse,
		note_position, input ready);
	modport sink (input valid, tone_on, period_compare, duty_compare, second_pulse,
		note_position, output ready);
endinterface

@@ rtl/core/mts_cfg_if.sv @@
// Configuration write channel interface.
interface mts_cfg_if import mts_pkg::*;;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/melody_tone_sequencer.sv @@
// Melody tone sequencer: note memory, tick timing and bit-serial tone arithmetic.
//
// Channel   Direction  Request holds
// cmd       in         action, note address, frequency, duration, song length
// status    out        tone on, period and duty compare, second pulse, note position
// cfg       in         register index and write data (volume, silence length)
//
// A write, a start, or a tick that does not load a note sets the result register directly.
// A tick that loads a note runs a memory read, then one shared restoring divider
// twice around a shift-add multiply; a zero frequency or quotient ends it early.
// Reset clears all control state at once; the note memory is not cleared.
// A new request is taken only when the block is idle and the result register
// is empty or being read in the same cycle.
module melody_tone_sequencer import mts_pkg::*; #(
	parameter int MAX_NOTES        = DEF_MAX_NOTES,
	parameter int TICKS_PER_SECOND = DEF_TICKS_PER_SECOND
) (
	input logic        clk,
	input logic        arst_n,
	mts_in_if.sink     cmd,
	mts_out_if.source  status,
	mts_cfg_if.sink    cfg
);

	localparam int AW = (MAX_NOTES > 1) ? $clog2(MAX_NOTES) : 1;
	localparam int PW = $clog2(MAX_NOTES + 1);
	localparam int CW = PW + LEN_W;
	localparam int SW = $clog2(TICKS_PER_SECOND);

	mts_state_t state_q, state_d;

	logic [VOL_W-1:0]  vol_q;
	logic [15:0]       sil_q;
	logic [FREQ_W+DUR_W-1:0] mem [MAX_NOTES];
	logic [FREQ_W+DUR_W-1:0] rd_q;
	logic              next_note_q;
	logic [PW-1:0]     ptr_q;
	logic [PW-1:0]     size_q;
	logic [15:0]       el_q;
	logic [15:0]       hold_q;
	logic [SW-1:0]     sc_q;
	logic              tone_q;
	logic [CMP_W-1:0]  period_q;
	logic [CMP_W-1:0]  duty_q;
	logic              pulse_q;
	logic              out_valid_q;
	logic [3:0]        cnt_q;
	logic [15:0]       rem_q;
	logic [15:0]       quo_q;
	logic [15:0]       dvs_q;
	logic [14:0]       prod_q;
	logic [14:0]       mc_q;
	logic [VOL_W-1:0]  mp_q;

	logic              accept;
	logic              load_note;
	logic              res_set;
	logic              can_play;
	logic              expire;
	logic              sec_wrap;
	logic [SW:0]       sc_inc;
	logic [15:0]       el_inc;
	logic [16:0]       trial;
	logic [16:0]       diff;
	logic              fits;
	logic [15:0]       rem_nxt;
	logic [15:0]       quo_nxt;
	logic              q_zero;
	logic [CMP_W-1:0]  q_sat;
	logic [14:0]       prod_add;
	logic [CW-1:0]     addr_ext;
	logic              wr_ok;
	logic [PW-1:0]     len_sat;
	logic [FREQ_W-1:0] rd_freq;
	logic [DUR_W-1:0]  rd_dur;

	assign rd_freq = rd_q[FREQ_W+DUR_W-1:DUR_W];
	assign rd_dur  = rd_q[DUR_W-1:0];

	always_comb begin
		accept   = cmd.valid && cmd.ready;
		sc_inc   = {1'b0, sc_q} + (SW+1)'(1);
		sec_wrap = sc_inc >= (SW+1)'(TICKS_PER_SECOND);
		el_inc   = el_q + 16'd1;
		expire   = el_inc >= hold_q;
		can_play = next_note_q && (ptr_q != size_q) && (CW'(ptr_q) < CW'(MAX_NOTES));
		load_note = accept && (cmd.action == ACT_TICK) && expire && can_play;
		addr_ext = CW'(cmd.note_address);
		wr_ok    = addr_ext < CW'(MAX_NOTES);
		len_sat  = (CW'(cmd.song_length) > CW'(MAX_NOTES)) ? PW'(MAX_NOTES)
			: PW'(cmd.song_length);
		trial    = {rem_q, quo_q[15]};
		diff     = trial - {1'b0, dvs_q};
		fits     = trial >= {1'b0, dvs_q};
		rem_nxt  = fits ? diff[15:0] : trial[15:0];
		quo_nxt  = {quo_q[14:0], fits};
		q_zero   = quo_nxt == 16'd0;
		q_sat    = (quo_nxt > 16'd255) ? 8'd255 : quo_nxt[7:0];
		prod_add = mp_q[0] ? (prod_q + mc_q) : prod_q;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (load_note) state_d = ST_FETCH;
			end
			ST_FETCH: begin
				state_d = (rd_freq == '0) ? ST_DONE : ST_PDIV;
			end
			ST_PDIV: begin
				if (cnt_q == DIV_LAST) state_d = q_zero ? ST_DONE : ST_MUL;
			end
			ST_MUL: begin
				if (cnt_q == MUL_LAST) state_d = ST_DDIV;
			end
			ST_DDIV: begin
				if (cnt_q == DIV_LAST) state_d = ST_DONE;
			end
			ST_DONE: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.ready = (state_q == ST_IDLE) && (!out_valid_q || status.ready);
		cfg.ready = 1'b1;
		res_set   = (accept && !load_note) || (state_q == ST_DONE);
		status.valid          = out_valid_q;
		status.tone_on        = tone_q;
		status.period_compare = period_q;
		status.duty_compare   = duty_q;
		status.second_pulse   = pulse_q;
		status.note_position  = POS_W'(ptr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			vol_q       <= '0;
			sil_q       <= SILENCE_RESET;
			next_note_q <= 1'b0;
			ptr_q       <= '0;
			size_q      <= '0;
			el_q        <= '0;
			hold_q      <= '0;
			sc_q        <= '0;
			tone_q      <= 1'b0;
			period_q    <= '0;
			duty_q      <= '0;
			pulse_q     <= 1'b0;
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_VOLUME:  vol_q <= cfg.data[VOL_W-1:0];
					CFG_SILENCE: sil_q <= cfg.data;
					default: ;
				endcase
			end
			if (res_set) out_valid_q <= 1'b1;
			else if (status.ready) out_valid_q <= 1'b0;
			if (accept) begin
				pulse_q <= (cmd.action == ACT_TICK) && sec_wrap;
				case (cmd.action)
					ACT_TICK: begin
						sc_q    <= sec_wrap ? '0 : sc_inc[SW-1:0];
						if (expire) begin
							el_q <= '0;
							if (can_play) begin
								next_note_q <= 1'b0;
								ptr_q       <= ptr_q + PW'(1);
							end else begin
								next_note_q <= 1'b1;
								tone_q      <= 1'b0;
								hold_q      <= sil_q;
							end
						end else begin
							el_q <= el_inc;
						end
					end
					ACT_START: begin
						size_q      <= len_sat;
						ptr_q       <= '0;
						next_note_q <= 1'b0;
						hold_q      <= '0;
					end
					default: ;
				endcase
			end
			case (state_q)
				ST_FETCH: begin
					hold_q <= rd_dur;
					cnt_q  <= '0;
					if (rd_freq == '0) tone_q <= 1'b0;
				end
				ST_PDIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) begin
						if (q_zero) begin
							tone_q <= 1'b0;
						end else begin
							tone_q   <= 1'b1;
							period_q <= q_sat - 8'd1;
						end
					end
				end
				ST_MUL: begin
					cnt_q <= (cnt_q == MUL_LAST) ? 4'd0 : cnt_q + 4'd1;
				end
				ST_DDIV: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == DIV_LAST) duty_q <= q_sat;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (cmd.action == ACT_WRITE) && wr_ok) begin
			mem[addr_ext[AW-1:0]] <= {cmd.note_frequency, cmd.note_duration};
		end
		if (load_note) rd_q <= mem[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_FETCH: begin
				rem_q <= '0;
				quo_q <= BASE_RATE;
				dvs_q <= rd_freq;
			end
			ST_PDIV: begin
				rem_q  <= rem_nxt;
				quo_q  <= quo_nxt;
				prod_q <= '0;
				mc_q   <= 15'(q_sat - 8'd1);
				mp_q   <= vol_q;
			end
			ST_MUL: begin
				prod_q <= prod_add;
				mc_q   <= {mc_q[13:0], 1'b0};
				mp_q   <= {1'b0, mp_q[VOL_W-1:1]};
				rem_q  <= '0;
				quo_q  <= {1'b0, prod_add};
				dvs_q  <= PERCENT;
			end
			ST_DDIV: begin
				rem_q <= rem_nxt;
				quo_q <= quo_nxt;
			end
			default: ;
		endcase
	end

endmodule
